/* hw/rtl/dled_pkg.sv */
// Shared types and constants for the DLE/ETX packet deframer.
// No dependencies; imported by every deframer module.
`timescale 1ns / 1ps

package dled_pkg;

    localparam logic [7:0] DLE_CODE = 8'h10;
    localparam logic [7:0] ETX_CODE = 8'h03;

    localparam int BUFFER_DEPTH_DEF = 256;

    // sync hunt: DLE ETX DLE then a non-DLE byte
    typedef enum logic [1:0] {
        SYNC_DLE1 = 2'd0,
        SYNC_ETX  = 2'd1,
        SYNC_DLE2 = 2'd2,
        SYNC_DATA = 2'd3
    } t_sync_phase;

    typedef struct packed {
        logic       store_valid;
        logic [7:0] store_index;
        logic [7:0] store_byte;
        logic       packet_done;
        logic [7:0] packet_length;
        logic       synced_now;
        logic       capturing;
        logic       overflow;
    } t_result;

endpackage

/* hw/rtl/dled_core.sv */
// Deframer state machine: sync hunt, packet capture, unstuffing and counting.
// Depends on dled_pkg.
`timescale 1ns / 1ps

module dled_core #(
    parameter int BUFFER_DEPTH = dled_pkg::BUFFER_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_advance,
    input  logic [7:0]        i_rx_byte,
    output dled_pkg::t_result o_result
);
    import dled_pkg::*;

    localparam int CNT_W = $clog2(BUFFER_DEPTH + 1);

    logic              r_capture, n_capture;
    t_sync_phase       r_phase, n_phase;
    logic              r_open, n_open;
    logic              r_stuff, n_stuff;
    logic [CNT_W-1:0]  r_count, n_count;
    logic              do_store;
    logic [CNT_W-1:0]  cnt_dec;
    t_result           res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capture <= 1'b0;
            r_phase   <= SYNC_DLE1;
            r_open    <= 1'b0;
            r_stuff   <= 1'b0;
            r_count   <= '0;
        end else if (i_advance) begin
            r_capture <= n_capture;
            r_phase   <= n_phase;
            r_open    <= n_open;
            r_stuff   <= n_stuff;
            r_count   <= n_count;
        end
    end

    always_comb begin
        n_capture = r_capture;
        n_phase   = r_phase;
        n_open    = r_open;
        n_stuff   = r_stuff;
        n_count   = r_count;
        do_store  = 1'b0;
        res       = '0;
        cnt_dec   = (r_count != '0) ? r_count - 1'b1 : '0;

        if (r_capture) begin
            if (!r_open) begin
                if (i_rx_byte == DLE_CODE) begin
                    n_open  = 1'b1;
                    n_stuff = 1'b0;
                end
            end else if (i_rx_byte == DLE_CODE) begin
                // second of a doubled DLE is dropped
                n_stuff  = !r_stuff;
                do_store = !r_stuff;
            end else if (i_rx_byte == ETX_CODE && r_stuff) begin
                // terminator: take back the DLE already stored
                res.packet_done   = 1'b1;
                res.packet_length = (32'(cnt_dec) > 32'd255) ? 8'd255 : 8'(cnt_dec);
                n_count = '0;
                n_open  = 1'b0;
                n_stuff = 1'b0;
            end else begin
                n_stuff  = 1'b0;
                do_store = 1'b1;
            end
        end else begin
            unique case (r_phase)
                SYNC_DLE1: n_phase = (i_rx_byte == DLE_CODE) ? SYNC_ETX : SYNC_DLE1;
                SYNC_ETX:  n_phase = (i_rx_byte == ETX_CODE) ? SYNC_DLE2 : SYNC_DLE1;
                SYNC_DLE2: n_phase = (i_rx_byte == DLE_CODE) ? SYNC_DATA : SYNC_DLE1;
                SYNC_DATA: begin
                    n_phase = SYNC_DLE1;
                    if (i_rx_byte != DLE_CODE) begin
                        do_store       = 1'b1;
                        n_open         = 1'b1;
                        n_stuff        = 1'b0;
                        n_capture      = 1'b1;
                        res.synced_now = 1'b1;
                    end
                end
            endcase
        end

        if (do_store) begin
            if (r_count < CNT_W'(BUFFER_DEPTH)) begin
                res.store_valid = 1'b1;
                res.store_index = 8'(r_count);
                res.store_byte  = i_rx_byte;
                n_count         = r_count + 1'b1;
            end else begin
                res.overflow = 1'b1;
            end
        end

        res.capturing = n_capture;
    end

    assign o_result = res;

endmodule

/* hw/rtl/dled_result_reg.sv */
// Result register between the deframer logic and the output channel.
// Depends on dled_pkg.
`timescale 1ns / 1ps

module dled_result_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  dled_pkg::t_result i_result,
    output logic              o_valid,
    input  logic              i_ready,
    output dled_pkg::t_result o_result
);
    import dled_pkg::*;

    logic    r_valid;
    t_result r_result;

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

/* hw/rtl/dle_etx_packet_deframer.sv */
// Top level of the DLE/ETX packet deframer: input register, core, result register.
// Depends on dled_pkg, dled_core and dled_result_reg.
`timescale 1ns / 1ps

// DLE/ETX deframer for a received serial byte stream. After reset the block
// hunts for DLE ETX DLE followed by a non-DLE byte; that byte is stored as the
// first packet byte and flagged with o_synced_now, and capture mode then holds
// until reset. In capture mode a DLE opens a packet, a doubled DLE stores one
// DLE, and DLE ETX closes the packet with o_packet_done and o_packet_length
// (saturated at 255). Every received byte gives exactly one output transaction;
// a stored byte shows o_store_valid with its buffer index (low 8 bits) and
// value, a byte dropped at a full buffer (BUFFER_DEPTH entries) shows
// o_overflow. Throughput is one transaction per clock while i_ready does not
// stall the output; each byte is held in the input register, then its decode
// and count update are captured in the result register, which drives the outputs.
// Backpressure from i_ready propagates combinationally to o_ready through both
// registers.

module dle_etx_packet_deframer #(
    parameter int BUFFER_DEPTH = dled_pkg::BUFFER_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // input byte channel
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_rx_byte,
    // result channel
    output logic       o_valid,
    input  logic       i_ready,
    output logic       o_store_valid,
    output logic [7:0] o_store_index,
    output logic [7:0] o_store_byte,
    output logic       o_packet_done,
    output logic [7:0] o_packet_length,
    output logic       o_synced_now,
    output logic       o_capturing,
    output logic       o_overflow
);
    import dled_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       res_ready;
    logic       advance;
    t_result    core_result;
    t_result    out_result;

    // input register; moves whenever the result stage can take its content
    assign o_ready = !r_in_valid || res_ready;
    assign advance = r_in_valid && res_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_in_byte <= i_rx_byte;
        end
    end

    // framing state advances only when the registered byte moves on
    dled_core #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_rx_byte (r_in_byte),
        .o_result  (core_result)
    );

    dled_result_reg u_result (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (r_in_valid),
        .o_ready  (res_ready),
        .i_result (core_result),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_result (out_result)
    );

    assign o_store_valid   = out_result.store_valid;
    assign o_store_index   = out_result.store_index;
    assign o_store_byte    = out_result.store_byte;
    assign o_packet_done   = out_result.packet_done;
    assign o_packet_length = out_result.packet_length;
    assign o_synced_now    = out_result.synced_now;
    assign o_capturing     = out_result.capturing;
    assign o_overflow      = out_result.overflow;

    // a byte is either stored or dropped, never both
    a_store_xor_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_store_valid && o_overflow))
        else $error("store and overflow in one transaction");

    // sync event stores the first byte and enters capture mode
    a_sync_stores: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_synced_now) |-> (o_capturing && o_store_valid && o_store_index == 8'd0))
        else $error("sync event without first store");

    // packet end only in capture mode and never with a store
    a_done_capture: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_packet_done) |-> (o_capturing && !o_store_valid && !o_overflow))
        else $error("packet end outside capture or with a store");

    // a stalled input register holds its byte
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !res_ready) |=> (r_in_valid && $stable(r_in_byte)))
        else $error("input register lost a stalled byte");

endmodule
